// ===== src/tps_pkg.sv =====
// Shared types, constants and helpers for the triangle pixel shader.
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;
  localparam int MAX_SIDE = 2048;
  localparam int COORD_FRAC_BITS = 4;
  localparam int SIDE_W = 12;
  localparam int ADDR_W = 22;
  localparam int WORD_W = 32;
  localparam int CFG_DATA_W = 56;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W = 16;
  // Edge values stay below 2^36 in magnitude; 38 bits signed is ample.
  localparam int EDGE_W = 38;
  localparam int MAG_W = 37;
  localparam int NUM_W = 47;
  localparam int QUO_W = 9;
  localparam logic [WORD_W-1:0] BACKGROUND_WORD = 32'hff030407;
  localparam logic [7:0] OPAQUE_BYTE = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_CORNER_A     = 3'd2,
    REG_CORNER_B     = 3'd3,
    REG_CORNER_C     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } corner_t;

  function automatic corner_t unpack_corner(input logic [CFG_DATA_W-1:0] w);
    corner_t c;
    c.x = w[15:0];
    c.y = w[31:16];
    c.red = w[39:32];
    c.green = w[47:40];
    c.blue = w[55:48];
    return c;
  endfunction

  function automatic logic [SIDE_W-1:0] side_limit(input logic [SIDE_W-1:0] v);
    return (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
  endfunction
endpackage
`default_nettype wire

// ===== src/tps_if.sv =====
// Valid/ready channel interfaces for pixel words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface tps_pixel_if;
  logic valid;
  logic ready;
  logic [tps_pkg::SIDE_W-1:0] pixel_col;
  logic [tps_pkg::SIDE_W-1:0] pixel_row;
  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink (input valid, pixel_col, pixel_row, output ready);
endinterface

interface tps_result_if;
  logic valid;
  logic ready;
  logic [tps_pkg::ADDR_W-1:0] pixel_address;
  logic [tps_pkg::WORD_W-1:0] pixel_word;
  modport source (output valid, pixel_address, pixel_word, input ready);
  modport sink (input valid, pixel_address, pixel_word, output ready);
endinterface
`default_nettype wire

// ===== src/tps_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, quotient below 512.
`timescale 1ns / 1ps
`default_nettype none
module tps_divider (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [tps_pkg::NUM_W-1:0]   num,
  input  wire logic [tps_pkg::MAG_W-1:0]   den,
  output logic      [tps_pkg::QUO_W-1:0]   quo
);
  localparam int Q = tps_pkg::QUO_W;
  localparam int RW = tps_pkg::MAG_W + 1;

  // The quotient fits in Q bits only while num stays below den * 2^Q.
  logic [tps_pkg::NUM_W-1:0] rem_r [Q+1];
  logic [tps_pkg::MAG_W-1:0] den_r [Q+1];
  logic [Q-1:0]              quo_r [Q+1];

  always_comb begin
    rem_r[0] = num;
    den_r[0] = den;
    quo_r[0] = '0;
  end

  for (genvar s = 0; s < Q; s++) begin : g_stage
    localparam int SH = Q - 1 - s;
    logic [RW-1:0] top;
    logic [RW-1:0] diff;
    logic [tps_pkg::NUM_W-1:0] rem_nxt;
    logic [tps_pkg::NUM_W-1:0] rem_q_r;
    logic [tps_pkg::MAG_W-1:0] den_q_r;
    logic [Q-1:0] quo_q_r;
    always_comb begin
      top = RW'(rem_r[s] >> SH);
      diff = top - {1'b0, den_r[s]};
      rem_nxt = rem_r[s];
      if (!diff[RW-1]) begin
        rem_nxt = rem_r[s] - (tps_pkg::NUM_W'(den_r[s]) << SH);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q_r <= rem_nxt;
        den_q_r <= den_r[s];
        quo_q_r <= {quo_r[s][Q-2:0], ~diff[RW-1]};
      end
    end
    always_comb begin
      rem_r[s+1] = rem_q_r;
      den_r[s+1] = den_q_r;
      quo_r[s+1] = quo_q_r;
    end
  end

  assign quo = quo_r[Q];
endmodule
`default_nettype wire

// ===== src/triangle_pixel_shader_top.sv =====
// An accepted pixel word passes stages 1-5, the divider and the output register.
// Throughput: one pixel per cycle; the whole pipeline stalls only when the output
// register is full and not taken. Out-of-frame pixels drop without a result.
// Reset: synchronous active-low rst_n clears valid bits and configuration registers.
// The user writes configuration registers only while the pipeline is empty; unenforced.
`timescale 1ns / 1ps
`default_nettype none
module triangle_pixel_shader_top (
  input  wire logic clk,
  input  wire logic rst_n,
  tps_pixel_if.sink    in_ch,
  tps_result_if.source out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tps_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int E = tps_pkg::EDGE_W;
  localparam int M = tps_pkg::MAG_W;
  localparam int N = tps_pkg::NUM_W;
  localparam int DIV_LAT = tps_pkg::QUO_W;
  localparam int HALF = 1 << (tps_pkg::COORD_FRAC_BITS - 1);

  logic [tps_pkg::SIDE_W-1:0] width_r, height_r;
  logic [tps_pkg::CFG_DATA_W-1:0] ca_r, cb_r, cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= '0; height_r <= '0; ca_r <= '0; cb_r <= '0; cc_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tps_pkg::REG_FRAME_WIDTH:  width_r <= cfg_data[tps_pkg::SIDE_W-1:0];
        tps_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data[tps_pkg::SIDE_W-1:0];
        tps_pkg::REG_CORNER_A:     ca_r <= cfg_data;
        tps_pkg::REG_CORNER_B:     cb_r <= cfg_data;
        tps_pkg::REG_CORNER_C:     cc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tps_pkg::corner_t v0, v1, v2;
  logic [tps_pkg::SIDE_W-1:0] w_lim, h_lim;
  assign v0 = tps_pkg::unpack_corner(ca_r);
  assign v1 = tps_pkg::unpack_corner(cb_r);
  assign v2 = tps_pkg::unpack_corner(cc_r);
  assign w_lim = tps_pkg::side_limit(width_r);
  assign h_lim = tps_pkg::side_limit(height_r);

  // Global stall: everything advances when the output register can take a word.
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Triangle setup from configuration only: area sign and magnitude.
  logic signed [E-1:0] area_s;
  logic [M-1:0] area_mag;
  logic area_neg, area_zero;
  always_comb begin
    area_s = (E'(v2.x) - E'(v0.x)) * (E'(v1.y) - E'(v0.y)) -
             (E'(v2.y) - E'(v0.y)) * (E'(v1.x) - E'(v0.x));
    area_neg = area_s[E-1];
    area_zero = (area_s == '0);
    area_mag = M'(area_neg ? -area_s : area_s);
  end

  // Stage 1: bounds check, pixel center, coordinate differences.
  logic s1_v_r;
  logic [tps_pkg::SIDE_W-1:0] s1_col_r, s1_row_r;
  logic signed [17:0] s1_dx_r [3];
  logic signed [17:0] s1_dy_r [3];
  logic signed [17:0] px, py;
  assign px = 18'({in_ch.pixel_col, tps_pkg::COORD_FRAC_BITS'(0)}) + 18'(HALF);
  assign py = 18'({in_ch.pixel_row, tps_pkg::COORD_FRAC_BITS'(0)}) + 18'(HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_ch.valid && (in_ch.pixel_col < w_lim) &&
                           (in_ch.pixel_row < h_lim);
    if (adv) begin
      s1_col_r <= in_ch.pixel_col;
      s1_row_r <= in_ch.pixel_row;
      s1_dx_r[0] <= px - 18'(v1.x); s1_dy_r[0] <= py - 18'(v1.y);
      s1_dx_r[1] <= px - 18'(v2.x); s1_dy_r[1] <= py - 18'(v2.y);
      s1_dx_r[2] <= px - 18'(v0.x); s1_dy_r[2] <= py - 18'(v0.y);
    end
  end

  // Stage 2: products of each edge function and the address multiply.
  logic signed [17:0] edx [3], edy [3];
  always_comb begin
    edx[0] = 18'(v2.x) - 18'(v1.x); edy[0] = 18'(v2.y) - 18'(v1.y);
    edx[1] = 18'(v0.x) - 18'(v2.x); edy[1] = 18'(v0.y) - 18'(v2.y);
    edx[2] = 18'(v1.x) - 18'(v0.x); edy[2] = 18'(v1.y) - 18'(v0.y);
  end
  logic s2_v_r;
  logic [tps_pkg::ADDR_W-1:0] s2_addr_r;
  logic signed [E-1:0] s2_pa_r [3], s2_pb_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv) begin
      s2_addr_r <= tps_pkg::ADDR_W'(s1_row_r * w_lim + tps_pkg::ADDR_W'(s1_col_r));
      for (int i = 0; i < 3; i++) begin
        s2_pa_r[i] <= E'(s1_dx_r[i]) * E'(edy[i]);
        s2_pb_r[i] <= E'(s1_dy_r[i]) * E'(edx[i]);
      end
    end
  end

  // Stage 3: edge values, inside test, magnitudes.
  logic s3_v_r, s3_in_r;
  logic [tps_pkg::ADDR_W-1:0] s3_addr_r;
  logic [M-1:0] s3_m_r [3];
  logic signed [E-1:0] ev [3];
  logic in_tri;
  always_comb begin
    in_tri = !area_zero;
    for (int i = 0; i < 3; i++) begin
      ev[i] = s2_pa_r[i] - s2_pb_r[i];
      if (ev[i] != '0 && (ev[i][E-1] != area_neg)) in_tri = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
    if (adv) begin
      s3_addr_r <= s2_addr_r;
      s3_in_r <= in_tri;
      for (int i = 0; i < 3; i++) s3_m_r[i] <= M'(ev[i][E-1] ? -ev[i] : ev[i]);
    end
  end

  // Stage 4: weighted channel products.
  logic s4_v_r, s4_in_r;
  logic [tps_pkg::ADDR_W-1:0] s4_addr_r;
  logic [N-1:0] s4_p_r [3][3];
  logic [7:0] chv [3][3];
  always_comb begin
    chv[0][0] = v0.red; chv[0][1] = v0.green; chv[0][2] = v0.blue;
    chv[1][0] = v1.red; chv[1][1] = v1.green; chv[1][2] = v1.blue;
    chv[2][0] = v2.red; chv[2][1] = v2.green; chv[2][2] = v2.blue;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
    if (adv) begin
      s4_addr_r <= s3_addr_r;
      s4_in_r <= s3_in_r;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) s4_p_r[k][i] <= N'(s3_m_r[i]) * N'(chv[i][k]);
    end
  end

  // Stage 5: numerator sums, then the divide pipeline.
  logic [N-1:0] s5_num_r [3];
  logic s5_v_r, s5_in_r;
  logic [tps_pkg::ADDR_W-1:0] s5_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= s4_v_r;
    if (adv) begin
      s5_addr_r <= s4_addr_r;
      s5_in_r <= s4_in_r;
      for (int k = 0; k < 3; k++) s5_num_r[k] <= s4_p_r[k][0] + s4_p_r[k][1] + s4_p_r[k][2];
    end
  end

  logic [tps_pkg::QUO_W-1:0] quo [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    tps_divider u_div (
      .clk (clk), .en (adv), .num (s5_num_r[k]),
      .den (area_zero ? M'(1) : area_mag), .quo (quo[k])
    );
  end

  // Side-band delay line alongside the divider stages.
  logic dl_v_r [DIV_LAT];
  logic dl_in_r [DIV_LAT];
  logic [tps_pkg::ADDR_W-1:0] dl_addr_r [DIV_LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_LAT; s++) dl_v_r[s] <= 1'b0;
    end else if (adv) begin
      dl_v_r[0] <= s5_v_r;
      for (int s = 1; s < DIV_LAT; s++) dl_v_r[s] <= dl_v_r[s-1];
    end
    if (adv) begin
      dl_in_r[0] <= s5_in_r; dl_addr_r[0] <= s5_addr_r;
      for (int s = 1; s < DIV_LAT; s++) begin
        dl_in_r[s] <= dl_in_r[s-1]; dl_addr_r[s] <= dl_addr_r[s-1];
      end
    end
  end

  // Output register.
  logic out_v_r;
  logic [tps_pkg::ADDR_W-1:0] out_addr_r;
  logic [tps_pkg::WORD_W-1:0] out_word_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) out_v_r <= dl_v_r[DIV_LAT-1];
    if (adv) begin
      out_addr_r <= dl_addr_r[DIV_LAT-1];
      out_word_r <= dl_in_r[DIV_LAT-1] ?
        {tps_pkg::OPAQUE_BYTE, quo[0][7:0], quo[1][7:0], quo[2][7:0]} :
        tps_pkg::BACKGROUND_WORD;
    end
  end
  assign out_ch.valid = out_v_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.pixel_word = out_word_r;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pixel_word))
    else $error("result word changed while stalled");
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.pixel_word[tps_pkg::WORD_W-1 -: 8] == tps_pkg::OPAQUE_BYTE)
    else $error("result word lacks the opaque top byte");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("input ready does not follow output stall");
`endif
endmodule
`default_nettype wire

// ===== tb/triangle_pixel_shader_top_tb.sv =====
// Self-checking testbench for the triangle pixel shader top level.
`timescale 1ns / 1ps
`default_nettype none
module triangle_pixel_shader_top_tb;
  import tps_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } shaded_pixel_t;

  // Scoreboard: predicts the shaded pixel for each accepted in-frame word and checks results.
  class shade_scoreboard;
    logic [SIDE_W-1:0] width_q, height_q;
    logic [CFG_DATA_W-1:0] corner_q [3];
    shaded_pixel_t pending [$];
    int errors;

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:  width_q = val[SIDE_W-1:0];
        REG_FRAME_HEIGHT: height_q = val[SIDE_W-1:0];
        REG_CORNER_A:     corner_q[0] = val;
        REG_CORNER_B:     corner_q[1] = val;
        REG_CORNER_C:     corner_q[2] = val;
        default: ;
      endcase
    endfunction

    function longint edge_fn(longint ax, longint ay, longint bx, longint by,
                             longint px, longint py);
      return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    function void note_pixel(logic [SIDE_W-1:0] col, logic [SIDE_W-1:0] row);
      longint w, h, px, py, area, e [3], m [3], ma, num, q;
      longint vx [3], vy [3], ch [3][3];
      logic [7:0] chan [3];
      bit ok;
      shaded_pixel_t r;
      w = (width_q > MAX_SIDE) ? MAX_SIDE : width_q;
      h = (height_q > MAX_SIDE) ? MAX_SIDE : height_q;
      if (col >= w || row >= h) return;
      for (int i = 0; i < 3; i++) begin
        vx[i] = longint'($signed(corner_q[i][15:0]));
        vy[i] = longint'($signed(corner_q[i][31:16]));
        for (int k = 0; k < 3; k++) ch[i][k] = corner_q[i][32+8*k +: 8];
      end
      px = (longint'(col) << COORD_FRAC_BITS) + (1 << (COORD_FRAC_BITS - 1));
      py = (longint'(row) << COORD_FRAC_BITS) + (1 << (COORD_FRAC_BITS - 1));
      r.word = BACKGROUND_WORD;
      area = edge_fn(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
      if (area != 0) begin
        e[0] = edge_fn(vx[1], vy[1], vx[2], vy[2], px, py);
        e[1] = edge_fn(vx[2], vy[2], vx[0], vy[0], px, py);
        e[2] = edge_fn(vx[0], vy[0], vx[1], vy[1], px, py);
        ok = 1;
        for (int i = 0; i < 3; i++)
          if (e[i] != 0 && ((e[i] > 0) != (area > 0))) ok = 0;
        if (ok) begin
          ma = (area < 0) ? -area : area;
          for (int i = 0; i < 3; i++) m[i] = (e[i] < 0) ? -e[i] : e[i];
          for (int k = 0; k < 3; k++) begin
            num = m[0] * ch[0][k] + m[1] * ch[1][k] + m[2] * ch[2][k];
            q = num / ma;
            chan[k] = (q > 255) ? 8'd255 : q[7:0];
          end
          r.word = {OPAQUE_BYTE, chan[0], chan[1], chan[2]};
        end
      end
      r.addr = ADDR_W'(row * w + col);
      pending.push_back(r);
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] word);
      shaded_pixel_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result word: address %0h word %08h", addr, word);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (addr !== exp_r.addr) begin
        $error("pixel_address: expected %0h actual %0h", exp_r.addr, addr);
        errors++;
      end
      if (word !== exp_r.word) begin
        $error("pixel_word: expected %08h actual %08h", exp_r.word, word);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 15;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int src_idle_pct = 0, snk_idle_pct = 0;
  longint cycle_count = 0;
  shade_scoreboard board;

  tps_pixel_if in_ch ();
  tps_result_if out_ch ();

  triangle_pixel_shader_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.pixel_col = '0;
    in_ch.pixel_row = '0;
    out_ch.ready = 0;
  end

  // Result side: random stalls, check at each accepted word.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.pixel_address, out_ch.pixel_word);
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The write enable stays high across back-to-back writes; set_frame drops it.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // Valid stays high between back-to-back words; it drops while idling and in drain.
  task automatic send_pixel(logic [SIDE_W-1:0] col, logic [SIDE_W-1:0] row);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.pixel_col <= col;
    in_ch.pixel_row <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_pixel(col, row);
  endtask

  // Drain outstanding results, then let the pipeline settle before touching registers.
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pack_corner(int x, int y, logic [23:0] rgb);
    logic [15:0] xs, ys;
    xs = x[15:0];
    ys = y[15:0];
    return {rgb[7:0], rgb[15:8], rgb[23:16], ys, xs};
  endfunction

  task automatic set_frame(int w, int h, logic [CFG_DATA_W-1:0] a,
                           logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] c);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_CORNER_A, a);
    write_reg(REG_CORNER_B, b);
    write_reg(REG_CORNER_C, c);
    cfg_we <= 0;
  endtask

  // A random triangle, mostly covering a region near the frame so pixels land inside.
  task automatic random_setting(int span);
    int w, h;
    logic [CFG_DATA_W-1:0] c [3];
    w = $urandom_range(1, span);
    h = $urandom_range(1, span);
    if ($urandom_range(9) == 0) w = $urandom_range(2049, 4095);
    if ($urandom_range(9) == 0) h = $urandom_range(2049, 4095);
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(7) == 0)
        c[i] = CFG_DATA_W'({$urandom(), $urandom()});
      else
        c[i] = pack_corner($urandom_range(0, (span + 4) * 16) - 32,
                           $urandom_range(0, (span + 4) * 16) - 32, 24'($urandom()));
    end
    if ($urandom_range(9) == 0) c[2] = c[$urandom_range(1)];
    set_frame(w, h, c[0], c[1], c[2]);
  endtask

  task automatic random_pixels(int n, int span);
    logic [SIDE_W-1:0] col, row;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        col = SIDE_W'($urandom());
        row = SIDE_W'($urandom());
      end else begin
        col = SIDE_W'($urandom_range(0, span));
        row = SIDE_W'($urandom_range(0, span));
      end
      send_pixel(col, row);
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset frame is empty, then the corners of a frame and triangle edges.
    send_pixel(0, 0);
    drain();
    set_frame(16, 16, pack_corner(0, 0, 24'hff0000), pack_corner(256, 0, 24'h00ff00),
              pack_corner(0, 256, 24'h0000ff));
    send_pixel(0, 0);
    send_pixel(15, 0);
    send_pixel(0, 15);
    send_pixel(15, 15);
    send_pixel(7, 7);
    send_pixel(16, 3);
    send_pixel(3, 16);
    send_pixel(12'hfff, 12'hfff);
    drain();
    // Opposite winding and an edge passing exactly through pixel centers.
    set_frame(16, 16, pack_corner(8, 8, 24'hffffff), pack_corner(8, 200, 24'h123456),
              pack_corner(200, 8, 24'h000000));
    send_pixel(0, 0);
    send_pixel(0, 5);
    send_pixel(5, 5);
    send_pixel(14, 14);
    drain();
    // Zero area.
    set_frame(16, 16, pack_corner(0, 0, 24'hffffff), pack_corner(100, 100, 24'hffffff),
              pack_corner(50, 50, 24'hffffff));
    send_pixel(2, 2);
    drain();
    // Extreme coordinates and the maximum side clamp.
    set_frame(4095, 4095, pack_corner(-32768, -32768, 24'hffffff),
              pack_corner(32767, -32768, 24'h808080), pack_corner(-32768, 32767, 24'h010203));
    send_pixel(2047, 2047);
    send_pixel(2048, 0);
    send_pixel(0, 2047);
    send_pixel(2047, 0);
    drain();
    set_frame(2048, 2048, pack_corner(32767, 32767, 24'hffffff),
              pack_corner(-32768, 32767, 24'h0), pack_corner(32767, -32768, 24'h55aa55));
    send_pixel(2047, 2047);
    send_pixel(0, 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 69 : 0;
      snk_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 9 : 0;
      for (int s = 0; s < 13; s++) begin
        random_setting((s % 4 == 0) ? 60 : 24);
        random_pixels(50, (s % 4 == 0) ? 64 : 28);
        drain();
      end
    end

    drain();
    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
